### rtl/lik_pkg.sv
// ----------------------------------------------------------------------------
// lik_pkg
// Shared widths, codes, item types and the CORDIC angle table for the leg
// inverse kinematics solver.
// ----------------------------------------------------------------------------
package lik_pkg;

    localparam int CORDIC_STAGES_DEF = 24;

    // port field widths
    localparam int POS_W   = 24;
    localparam int LEN_W   = 22;
    localparam int ANG_W   = 17;
    localparam int MODE_W  = 2;
    localparam int ST_W    = 2;
    localparam int CIDX_W  = 2;

    // internal datapath widths
    localparam int H_W     = 32;   // drop h, Q19 mm
    localparam int A_W     = 33;   // femur offset a, Q19 mm
    localparam int CW      = 57;   // CORDIC x/y
    localparam int ZW      = 26;   // CORDIC angle, deg Q16
    localparam int WRAP_W  = 20;   // angle before wrap, deg Q8

    localparam logic signed [ZW-1:0]     HALF_TURN_Q16 = 26'sd11796480;
    localparam logic signed [WRAP_W-1:0] HALF_TURN_Q8  = 20'sd46080;
    localparam logic signed [WRAP_W-1:0] FULL_TURN_Q8  = 20'sd92160;

    // status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_REFLECT = 2'd1;
    localparam logic [ST_W-1:0] ST_FAR     = 2'd2;
    localparam logic [ST_W-1:0] ST_NEAR    = 2'd3;

    // projection modes
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RADIAL = 2'd1;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_COXA  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_RIGID = 2'd1;
    localparam logic [CIDX_W-1:0] REG_PITCH = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [H_W-1:0]    h;
        logic        [MODE_W-1:0] mode;
    } geo_t;

    typedef struct packed {
        geo_t                   geo;
        logic signed [A_W-1:0]  a;
        logic signed [A_W-1:0]  aref;
    } leg_t;

    // atan(2^-i) in degrees Q16, rounded
    function automatic logic signed [ZW-1:0] atan_q16(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 26'sd2949120;
            1:  v = 26'sd1740967;
            2:  v = 26'sd919879;
            3:  v = 26'sd466945;
            4:  v = 26'sd234379;
            5:  v = 26'sd117304;
            6:  v = 26'sd58666;
            7:  v = 26'sd29335;
            8:  v = 26'sd14668;
            9:  v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            16: v = 26'sd57;
            17: v = 26'sd29;
            18: v = 26'sd14;
            19: v = 26'sd7;
            20: v = 26'sd4;
            21: v = 26'sd2;
            22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/lik_isqrt.sv
// ----------------------------------------------------------------------------
// lik_isqrt
// Floor integer square root as a chain of cells, one root bit per cell,
// with a sideband that travels alongside each item.
// ----------------------------------------------------------------------------
module lik_isqrt #(
    parameter int RW = 64,
    parameter int SW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [RW-1:0]    rad,
    input  logic [SW-1:0]    side_i,
    output logic             out_valid,
    output logic [RW/2-1:0]  root,
    output logic [SW-1:0]    side_o
);
    localparam int N = RW / 2;

    logic          vld_reg  [0:N-1];
    logic [RW-1:0] rem_reg  [0:N-1];
    logic [N-1:0]  root_reg [0:N-1];
    logic [SW-1:0] side_reg [0:N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_cell
            localparam int B = N - 1 - k;
            logic          vld_c;
            logic [RW-1:0] rem_c;
            logic [N-1:0]  root_c;
            logic [SW-1:0] side_c;
            logic [RW-1:0] trial;
            logic [RW-1:0] rem_next;
            logic [N-1:0]  root_next;

            if (k == 0)
            begin : g_head
                assign vld_c  = in_valid;
                assign rem_c  = rad;
                assign root_c = '0;
                assign side_c = side_i;
            end
            else
            begin : g_link
                assign vld_c  = vld_reg[k-1];
                assign rem_c  = rem_reg[k-1];
                assign root_c = root_reg[k-1];
                assign side_c = side_reg[k-1];
            end

            // (root + 2^B)^2 - root^2
            assign trial = ({{N{1'b0}}, root_c} << (B + 1)) | (RW'(1) << (2 * B));

            always_comb
            begin
                if (rem_c >= trial)
                begin
                    rem_next  = rem_c - trial;
                    root_next = root_c | (N'(1) << B);
                end
                else
                begin
                    rem_next  = rem_c;
                    root_next = root_c;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (adv)
                    vld_reg[k] <= vld_c;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    side_reg[k] <= side_c;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];
    assign side_o    = side_reg[N-1];

endmodule

### rtl/lik_cordic.sv
// ----------------------------------------------------------------------------
// lik_cordic
// Vectoring CORDIC atan2 as a chain of cells: a half-plane fold stage, then
// one micro-rotation per cell. Angle in degrees Q16, zero for a zero vector.
// ----------------------------------------------------------------------------
module lik_cordic #(
    parameter int STAGES = lik_pkg::CORDIC_STAGES_DEF,
    parameter int SW     = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic signed [lik_pkg::CW-1:0] xi,
    input  logic signed [lik_pkg::CW-1:0] yi,
    input  logic [SW-1:0]                 side_i,
    output logic                          out_valid,
    output logic signed [lik_pkg::ZW-1:0] angle,
    output logic [SW-1:0]                 side_o
);
    import lik_pkg::*;

    logic                 vld_reg  [0:STAGES];
    logic signed [CW-1:0] x_reg    [0:STAGES];
    logic signed [CW-1:0] y_reg    [0:STAGES];
    logic signed [ZW-1:0] z_reg    [0:STAGES];
    logic                 zero_reg [0:STAGES];
    logic [SW-1:0]        side_reg [0:STAGES];

    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [ZW-1:0] z_next;

    // fold the left half plane by a half turn
    always_comb
    begin
        if (xi < 0)
        begin
            x_next = -xi;
            y_next = -yi;
            z_next = (yi >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
        end
        else
        begin
            x_next = xi;
            y_next = yi;
            z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= (xi == '0) && (yi == '0);
            side_reg[0] <= side_i;
        end
    end

    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_cell
            localparam logic signed [ZW-1:0] ANG = atan_q16(k);
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;

            assign dx = y_reg[k] >>> k;
            assign dy = x_reg[k] >>> k;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k+1] <= 1'b0;
                else if (adv)
                    vld_reg[k+1] <= vld_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (y_reg[k] >= 0)
                    begin
                        x_reg[k+1] <= x_reg[k] + dx;
                        y_reg[k+1] <= y_reg[k] - dy;
                        z_reg[k+1] <= z_reg[k] + ANG;
                    end
                    else
                    begin
                        x_reg[k+1] <= x_reg[k] - dx;
                        y_reg[k+1] <= y_reg[k] + dy;
                        z_reg[k+1] <= z_reg[k] - ANG;
                    end
                    zero_reg[k+1] <= zero_reg[k];
                    side_reg[k+1] <= side_reg[k];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[STAGES];
    assign angle     = zero_reg[STAGES] ? '0 : z_reg[STAGES];
    assign side_o    = side_reg[STAGES];

endmodule

### rtl/leg_inverse_kinematics_solver.sv
// ----------------------------------------------------------------------------
// leg_inverse_kinematics_solver
// Two-link leg inverse kinematics: coxa yaw and femur pitch from a foot
// target, with reflected-branch fallback and reach/height projection.
// ----------------------------------------------------------------------------
// Path: from input accept to out_valid an item passes through the two 31/32-cell
//   square root chains in series and then the CORDIC.
// Throughput: one item per cycle; a two-entry output buffer holds results
//   while out_stall is high, and in_stall rises only once both are full.
// Reset: rst_n clears all valid bits and the configuration registers to zero.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics_solver #(
    parameter int CORDIC_STAGES = lik_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [lik_pkg::POS_W-1:0]   target_x,
    input  logic signed [lik_pkg::POS_W-1:0]   target_y,
    input  logic signed [lik_pkg::POS_W-1:0]   target_z,
    input  logic        [lik_pkg::MODE_W-1:0]  projection_mode,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic        [lik_pkg::ST_W-1:0]    status,
    output logic signed [lik_pkg::ANG_W-1:0]   coxa_angle,
    output logic signed [lik_pkg::ANG_W-1:0]   femur_angle,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic        [lik_pkg::CIDX_W-1:0]  cfg_index,
    input  logic        [lik_pkg::LEN_W-1:0]   cfg_data
);
    import lik_pkg::*;

    localparam int RA_W = 62;            // reach radicand
    localparam int RB_W = 64;            // distance / projection radicand
    localparam int R_W  = RA_W / 2;
    localparam int D_W  = RB_W / 2;
    localparam int LQ_W = LEN_W + 7;     // length in Q19

    function automatic logic signed [ANG_W-1:0] wrap_q8(input logic signed [WRAP_W-1:0] v);
        logic signed [WRAP_W-1:0] w;
        if (v > HALF_TURN_Q8)
            w = v - FULL_TURN_Q8;
        else if (v <= -HALF_TURN_Q8)
            w = v + FULL_TURN_Q8;
        else
            w = v;
        return w[ANG_W-1:0];
    endfunction

    // ---------------- configuration ----------------
    logic [LEN_W-1:0]        coxa_reg;
    logic [LEN_W-1:0]        rigid_reg;
    logic signed [ANG_W-1:0] psi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coxa_reg  <= '0;
            rigid_reg <= '0;
            psi_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COXA:  coxa_reg  <= cfg_data;
                REG_RIGID: rigid_reg <= cfg_data;
                REG_PITCH: psi_reg   <= cfg_data[ANG_W-1:0];
                default:   ;
            endcase
        end
    end

    logic [LQ_W-1:0] l1q;
    logic [LQ_W-1:0] rq;
    logic [11:0]     tol;

    assign l1q = {coxa_reg, 7'b0};
    assign rq  = {rigid_reg, 7'b0};
    assign tol = rigid_reg[LEN_W-1:10];

    // ---------------- flow control ----------------
    logic skid_full_reg;
    logic adv;

    assign adv      = !skid_full_reg;
    assign in_stall = skid_full_reg;

    // ---------------- S0: input register ----------------
    logic                    v0_reg;
    logic signed [POS_W-1:0] x0_reg, y0_reg, z0_reg;
    logic [MODE_W-1:0]       m0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg <= target_x;
            y0_reg <= target_y;
            z0_reg <= target_z;
            m0_reg <= projection_mode;
        end
    end

    // ---------------- S1: squares of x, y; drop h ----------------
    logic                        v1_reg;
    logic signed [2*POS_W-1:0]   xx1_reg, yy1_reg;
    geo_t                        geo1_reg;
    logic signed [H_W-1:0]       z_ext;

    assign z_ext = H_W'(z0_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xx1_reg       <= x0_reg * x0_reg;
            yy1_reg       <= y0_reg * y0_reg;
            geo1_reg.x    <= x0_reg;
            geo1_reg.y    <= y0_reg;
            geo1_reg.h    <= -(z_ext <<< 7);
            geo1_reg.mode <= m0_reg;
        end
    end

    // ---------------- S2: x^2 + y^2 ----------------
    logic              v2_reg;
    logic [2*POS_W-1:0] sum2_reg;
    geo_t              geo2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum2_reg <= $unsigned(xx1_reg) + $unsigned(yy1_reg);
            geo2_reg <= geo1_reg;
        end
    end

    // ---------------- reach r ----------------
    logic           va;
    logic [R_W-1:0] r_a;
    geo_t           geo_a;

    lik_isqrt #(.RW(RA_W), .SW($bits(geo_t))) u_reach (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v2_reg),
        .rad       ({sum2_reg, 14'b0}),
        .side_i    (geo2_reg),
        .out_valid (va),
        .root      (r_a),
        .side_o    (geo_a)
    );

    // ---------------- S3: direct and reflected offsets ----------------
    logic                  v3_reg;
    logic signed [A_W-1:0] a3_reg, ar3_reg;
    geo_t                  geo3_reg;
    logic signed [A_W-1:0] r_s, l1_s;

    assign r_s  = $signed({2'b0, r_a});
    assign l1_s = $signed({4'b0, l1q});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= va;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a3_reg   <= r_s - l1_s;
            ar3_reg  <= -(r_s + l1_s);
            geo3_reg <= geo_a;
        end
    end

    // ---------------- S4: squares ----------------
    logic                    v4_reg;
    logic [RB_W-1:0]         a2_4_reg, ar2_4_reg, h2_4_reg;
    logic [2*LEN_W-1:0]      rig2_4_reg;
    leg_t                    leg4_reg;
    logic signed [2*A_W-1:0] a_sq, ar_sq;
    logic signed [2*H_W-1:0] h_sq;

    assign a_sq  = a3_reg * a3_reg;
    assign ar_sq = ar3_reg * ar3_reg;
    assign h_sq  = geo3_reg.h * geo3_reg.h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a2_4_reg      <= a_sq[RB_W-1:0];
            ar2_4_reg     <= ar_sq[RB_W-1:0];
            h2_4_reg      <= h_sq[RB_W-1:0];
            rig2_4_reg    <= rigid_reg * rigid_reg;
            leg4_reg.geo  <= geo3_reg;
            leg4_reg.a    <= a3_reg;
            leg4_reg.aref <= ar3_reg;
        end
    end

    // ---------------- S5: radicands ----------------
    logic            v5_reg;
    logic [RB_W-1:0] rd5_reg, rr5_reg, rap5_reg, rhp5_reg;
    leg_t            leg5_reg;
    logic [RB_W-1:0] rq2;

    assign rq2 = {6'b0, rig2_4_reg, 14'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (adv)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd5_reg  <= a2_4_reg + h2_4_reg;
            rr5_reg  <= ar2_4_reg + h2_4_reg;
            rap5_reg <= rq2 - h2_4_reg;
            rhp5_reg <= rq2 - a2_4_reg;
            leg5_reg <= leg4_reg;
        end
    end

    // ---------------- distances and projections ----------------
    logic           vb;
    logic [D_W-1:0] dist_b, dref_b, ap_b, hp_b;
    leg_t           leg_b;

    lik_isqrt #(.RW(RB_W), .SW($bits(leg_t))) u_dist (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(v5_reg),
        .rad(rd5_reg), .side_i(leg5_reg),
        .out_valid(vb), .root(dist_b), .side_o(leg_b)
    );

    lik_isqrt #(.RW(RB_W), .SW(1)) u_dref (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(v5_reg),
        .rad(rr5_reg), .side_i(1'b0),
        .out_valid(), .root(dref_b), .side_o()
    );

    lik_isqrt #(.RW(RB_W), .SW(1)) u_aproj (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(v5_reg),
        .rad(rap5_reg), .side_i(1'b0),
        .out_valid(), .root(ap_b), .side_o()
    );

    lik_isqrt #(.RW(RB_W), .SW(1)) u_hproj (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(v5_reg),
        .rad(rhp5_reg), .side_i(1'b0),
        .out_valid(), .root(hp_b), .side_o()
    );

    // ---------------- S6: branch and projection decision ----------------
    logic [D_W-1:0]        band_lo, band_hi, rq_d;
    logic                  in_d, in_r;
    logic signed [A_W:0]   rq_s, h_s, a_s;
    logic [ST_W-1:0]       st_next;
    logic signed [A_W-1:0] a_next;
    logic signed [H_W-1:0] h_next;

    assign rq_d    = D_W'(rq);
    assign band_lo = rq_d - D_W'(tol);
    assign band_hi = rq_d + D_W'(tol);
    assign in_d    = (dist_b >= band_lo) && (dist_b <= band_hi);
    assign in_r    = (dref_b >= band_lo) && (dref_b <= band_hi);
    assign rq_s    = $signed({5'b0, rq});
    assign h_s     = (A_W + 1)'(leg_b.geo.h);
    assign a_s     = (A_W + 1)'(leg_b.a);

    always_comb
    begin
        st_next = ST_OK;
        a_next  = leg_b.a;
        h_next  = leg_b.geo.h;
        if (!in_d)
        begin
            if (in_r)
            begin
                st_next = ST_REFLECT;
                a_next  = leg_b.aref;
            end
            else
            begin
                case (leg_b.geo.mode)
                    MODE_NONE:
                        st_next = (dist_b > rq_d) ? ST_FAR : ST_NEAR;
                    MODE_RADIAL:
                    begin
                        if (h_s > rq_s || h_s < -rq_s)
                            st_next = ST_FAR;
                        else
                            a_next = $signed({1'b0, ap_b});
                    end
                    default:
                    begin
                        // hold reach, clamp height
                        if (a_s > rq_s || a_s < -rq_s)
                            st_next = ST_FAR;
                        else
                            h_next = $signed(hp_b);
                    end
                endcase
            end
        end
    end

    logic                    v6_reg;
    logic [ST_W-1:0]         st6_reg;
    logic signed [A_W-1:0]   a6_reg;
    logic signed [H_W-1:0]   h6_reg;
    logic signed [POS_W-1:0] x6_reg, y6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (adv)
            v6_reg <= vb;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st6_reg <= st_next;
            a6_reg  <= a_next;
            h6_reg  <= h_next;
            x6_reg  <= leg_b.geo.x;
            y6_reg  <= leg_b.geo.y;
        end
    end

    // ---------------- angles ----------------
    logic                 vc;
    logic [ST_W-1:0]      st_c;
    logic signed [ZW-1:0] z1_c, z2_c;

    lik_cordic #(.STAGES(CORDIC_STAGES), .SW(ST_W)) u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v6_reg),
        .xi        (CW'(x6_reg) <<< 29),
        .yi        (CW'(y6_reg) <<< 29),
        .side_i    (st6_reg),
        .out_valid (vc),
        .angle     (z1_c),
        .side_o    (st_c)
    );

    lik_cordic #(.STAGES(CORDIC_STAGES), .SW(1)) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v6_reg),
        .xi        (CW'(a6_reg) <<< 22),
        .yi        (CW'(h6_reg) <<< 22),
        .side_i    (1'b0),
        .out_valid (),
        .angle     (z2_c),
        .side_o    ()
    );

    // ---------------- final rounding and wrap ----------------
    logic signed [ZW:0]       zr1, zr2;
    logic signed [WRAP_W-1:0] t1, t2;
    logic                     err;
    logic signed [ANG_W-1:0]  coxa_fin, femur_fin;

    assign zr1 = (ZW + 1)'(z1_c) + (ZW + 1)'(128);
    assign zr2 = (ZW + 1)'(z2_c) + (ZW + 1)'(128);
    assign t1  = WRAP_W'($signed(zr1[ZW:8]))
               + ((st_c == ST_REFLECT) ? HALF_TURN_Q8 : WRAP_W'(0));
    assign t2  = WRAP_W'($signed(zr2[ZW:8])) - WRAP_W'(psi_reg);
    assign err = (st_c == ST_FAR) || (st_c == ST_NEAR);
    assign coxa_fin  = err ? '0 : wrap_q8(t1);
    assign femur_fin = err ? '0 : wrap_q8(t2);

    // ---------------- output register and skid entry ----------------
    logic                    out_valid_reg;
    logic [ST_W-1:0]         st_out_reg, st_skid_reg;
    logic signed [ANG_W-1:0] coxa_out_reg, femur_out_reg;
    logic signed [ANG_W-1:0] coxa_skid_reg, femur_skid_reg;
    logic                    take, fin_v;
    logic                    out_valid_next, skid_full_next;
    logic                    load_out_fin, load_out_skid, load_skid;

    assign take  = out_valid_reg && !out_stall;
    assign fin_v = adv && vc;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_full_next = skid_full_reg;
        load_out_fin   = 1'b0;
        load_out_skid  = 1'b0;
        load_skid      = 1'b0;
        if (skid_full_reg)
        begin
            if (take)
            begin
                load_out_skid  = 1'b1;
                skid_full_next = 1'b0;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_next = fin_v;
            load_out_fin   = fin_v;
        end
        else if (fin_v)
        begin
            // output held: park the item
            skid_full_next = 1'b1;
            load_skid      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_fin)
        begin
            st_out_reg    <= st_c;
            coxa_out_reg  <= coxa_fin;
            femur_out_reg <= femur_fin;
        end
        else if (load_out_skid)
        begin
            st_out_reg    <= st_skid_reg;
            coxa_out_reg  <= coxa_skid_reg;
            femur_out_reg <= femur_skid_reg;
        end
        if (load_skid)
        begin
            st_skid_reg    <= st_c;
            coxa_skid_reg  <= coxa_fin;
            femur_skid_reg <= femur_fin;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = st_out_reg;
    assign coxa_angle  = coxa_out_reg;
    assign femur_angle = femur_out_reg;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid entry filled without a held output");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (st_out_reg == ST_FAR || st_out_reg == ST_NEAR)
        |-> coxa_out_reg == '0 && femur_out_reg == '0)
        else $error("error result carries nonzero angles");

    a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> WRAP_W'(coxa_out_reg) > -HALF_TURN_Q8
                          && WRAP_W'(femur_out_reg) > -HALF_TURN_Q8)
        else $error("angle outside wrapped range");

endmodule
